// File: hw/rtl/imac_pkg.sv
// shared types, widths, constants and rounding helpers for the imu motion integrator
// used by imac_mul, imac_div and imu_motion_accel_integrator_top
`default_nettype none

package imac_pkg;

   // stream word widths
   localparam int IN_DATA_W  = 144;
   localparam int OUT_DATA_W = 160;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // field widths
   localparam int ACC_W  = 16;
   localparam int Q_W    = 16;
   localparam int YAW_W  = 15;
   localparam int TIME_W = 16;
   localparam int VEL_W  = 32;
   localparam int POS_W  = 48;

   // shared digit-serial multiplier: signed a times signed b
   localparam int MUL_AW    = 34;
   localparam int MUL_BW    = 20;
   localparam int MUL_DIGIT = 4;
   localparam int MUL_STEPS = MUL_BW / MUL_DIGIT;
   localparam int MUL_PW    = MUL_AW + MUL_DIGIT + MUL_BW;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
   localparam int PROD_W    = 56;

   // bit-serial divider: unsigned numerator over unsigned denominator
   localparam int DIV_NW    = 38;
   localparam int DIV_DW    = TIME_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

   // filter numerator and gravity widths
   localparam int NUM_W = 40;
   localparam int GB_W  = 22;
   localparam int D_W   = GB_W + 1;

   localparam int PROD_CNT = 9;

   localparam logic signed [MUL_AW-1:0] K_HALF    = MUL_AW'(134217728);
   localparam logic signed [PROD_W-1:0] RND_HALF  = PROD_W'(134217728);
   localparam int                       RND_SHIFT = 28;
   localparam logic signed [MUL_BW-1:0] GRAVITY_Q10 = MUL_BW'(10045);
   localparam logic signed [16:0]       PI_Q12      = 17'sd12868;
   localparam logic signed [31:0]       TURN_Q12    = 32'sd25735;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOWPASS_TIME = 3'd0,
      CSR_DEADBAND_HOR = 3'd1,
      CSR_DEADBAND_VER = 3'd2,
      CSR_STILL_LIMIT  = 3'd3,
      CSR_WARMUP_STEPS = 3'd4
   } csr_index_type;

   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic                     start;
      logic signed [MUL_AW-1:0] a;
      logic signed [MUL_BW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      prod_type prod;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_NW-1:0] quot;
   } div_rsp_type;

   // shift right by 28, round half away from zero
   function automatic prod_type rsr28(input prod_type v);
      prod_type r;
      if (v >= 0) begin
         r = (v + RND_HALF) >>> RND_SHIFT;
      end else begin
         r = -((-v + RND_HALF) >>> RND_SHIFT);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input prod_type v);
      logic signed [15:0] r;
      if (v > prod_type'(32767)) begin
         r = 16'sh7fff;
      end else if (v < prod_type'(-32768)) begin
         r = -16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/imac_mul.sv
// shared signed multiplier, one 4-bit digit of b per cycle
// depends on imac_pkg
`default_nettype none

module imac_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire imac_pkg::mul_req_type req,
   output imac_pkg::mul_rsp_type     rsp
);
   import imac_pkg::*;

   logic [MUL_AW-1:0]    amag_ff, amag_in;
   logic [MUL_BW-1:0]    bsh_ff, bsh_in;
   logic [MUL_PW-1:0]    p_ff, p_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;

   logic [MUL_AW+MUL_DIGIT-1:0] partial;
   logic [MUL_AW+MUL_DIGIT:0]   hi_sum;
   logic [MUL_PW:0]             shifted;

   assign partial = (MUL_AW+MUL_DIGIT)'(amag_ff) *
                    (MUL_AW+MUL_DIGIT)'(bsh_ff[MUL_DIGIT-1:0]);
   assign hi_sum  = {1'b0, p_ff[MUL_PW-1:MUL_BW]} + {1'b0, partial};
   assign shifted = {hi_sum, p_ff[MUL_BW-1:0]} >> MUL_DIGIT;

   always_comb begin
      amag_in = amag_ff;
      bsh_in  = bsh_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (req.start) begin
         amag_in = req.a[MUL_AW-1] ? MUL_AW'(-req.a) : MUL_AW'(req.a);
         bsh_in  = req.b[MUL_BW-1] ? MUL_BW'(-req.b) : MUL_BW'(req.b);
         neg_in  = req.a[MUL_AW-1] ^ req.b[MUL_BW-1];
         p_in    = '0;
         cnt_in  = MUL_CNT_W'(MUL_STEPS);
      end else if (cnt_ff != '0) begin
         p_in    = shifted[MUL_PW-1:0];
         bsh_in  = bsh_ff >> MUL_DIGIT;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == MUL_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      amag_ff <= amag_in;
      bsh_ff  <= bsh_in;
      p_ff    <= p_in;
      neg_ff  <= neg_in;
   end

   assign rsp.busy = (cnt_ff != '0);
   assign rsp.done = done_ff;
   assign rsp.prod = neg_ff ? -$signed(p_ff[PROD_W-1:0]) : $signed(p_ff[PROD_W-1:0]);

endmodule

`default_nettype wire

// File: hw/rtl/imac_div.sv
// restoring divider, one quotient bit per cycle
// depends on imac_pkg
`default_nettype none

module imac_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire imac_pkg::div_req_type req,
   output imac_pkg::div_rsp_type     rsp
);
   import imac_pkg::*;

   logic [DIV_NW-1:0]    q_ff, q_in;
   logic [DIV_DW-1:0]    rem_ff, rem_in;
   logic [DIV_DW-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [DIV_DW:0] trial;
   logic [DIV_DW:0] diff;
   logic            ge;

   assign trial = {rem_ff, q_ff[DIV_NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         q_in   = req.num;
         rem_in = '0;
         den_in = req.den;
         cnt_in = DIV_CNT_W'(DIV_NW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         q_in    = {q_ff[DIV_NW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = (cnt_ff != '0);
   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule

`default_nettype wire

// File: hw/rtl/imu_motion_accel_integrator_top.sv
// imu motion integrator top: gravity removal, low-pass, earth rotation, deadband,
// velocity/position integration and yaw unwrap; uses imac_pkg, imac_mul, imac_div
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+----------------------------------------------
// req      | in  | req_tvalid/tready    | req_tdata: accel xyz, quat wxyz, yaw, step time
// rsp      | out | rsp_tvalid/tready    | rsp_tdata: earth accel xyz, vel, pos, yaw total
//          |     |                      | rsp_tuser: ready_res
// csr      | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// one word at a time: each word takes 27 products on the shared 4-bit-digit multiplier
// and three 38-bit quotients on the bit-serial divider, or 21 products and no quotients
// when lowpass time and step time are both zero
// a new word is taken once the previous result sits in the output register
// reset is synchronous and restores the register defaults and clears the control and persistent state
// a stalled result holds the sequencer in its last state, which also keeps req_tready low
`default_nettype none

module imu_motion_accel_integrator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z, yaw_angle, step_time_us
   input  wire logic [imac_pkg::IN_DATA_W-1:0]       req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // earth_accel_x, earth_accel_y, earth_accel_z, velocity, position, yaw_total
   output logic [imac_pkg::OUT_DATA_W-1:0]           rsp_tdata,
   // ready_res
   output logic                                      rsp_tuser,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [imac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [imac_pkg::CSR_DATA_W-1:0]      csr_data
);
   import imac_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_QP, S_GB, S_FD, S_FM, S_DV, S_RT, S_RND, S_UPD, S_POS, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] col_ff, col_in;
   logic       go_ff, go_in;

   // configuration
   logic [15:0] tc_ff, tc_in;
   logic [9:0]  dbh_ff, dbh_in;
   logic [9:0]  dbv_ff, dbv_in;
   logic [7:0]  lim_ff, lim_in;
   logic [15:0] wsteps_ff, wsteps_in;

   // captured input word
   logic signed [ACC_W-1:0] acc_ff [3], acc_in [3];
   logic signed [Q_W-1:0]   q_ff [4], q_in [4];
   logic signed [YAW_W-1:0] yaw_ff, yaw_in;
   logic [TIME_W-1:0]       dt_ff, dt_in;

   // working values
   logic signed [31:0]     p_ff [PROD_CNT], p_in [PROD_CNT];
   logic signed [GB_W-1:0] gb_ff [3], gb_in [3];
   logic signed [NUM_W-1:0] num_ff, num_in;
   prod_type               racc_ff, racc_in;
   logic signed [15:0]     e_ff [3], e_in [3];
   logic                   run_ff, run_in;

   // persistent state
   logic signed [15:0]    m_ff [3], m_in [3];
   logic signed [VEL_W-1:0] vel_ff, vel_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]            still_ff, still_in;
   logic [15:0]           warm_ff, warm_in;
   logic signed [15:0]    turns_ff, turns_in;
   logic signed [15:0]    yprev_ff, yprev_in;
   logic                  rdy_ff, rdy_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   imac_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   imac_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   // doubled rotation coefficients, Q28
   logic signed [MUL_AW-1:0] k00, k01, k02, k10, k11, k12, k20, k21, k22;
   logic signed [MUL_AW-1:0] pw01, pw02, pw03, pw12, pw13, pw23, pw11, pw22, pw33;

   assign pw01 = MUL_AW'(p_ff[0]);
   assign pw02 = MUL_AW'(p_ff[1]);
   assign pw03 = MUL_AW'(p_ff[2]);
   assign pw12 = MUL_AW'(p_ff[3]);
   assign pw13 = MUL_AW'(p_ff[4]);
   assign pw23 = MUL_AW'(p_ff[5]);
   assign pw11 = MUL_AW'(p_ff[6]);
   assign pw22 = MUL_AW'(p_ff[7]);
   assign pw33 = MUL_AW'(p_ff[8]);

   assign k00 = (K_HALF - pw22 - pw33) <<< 1;
   assign k01 = (pw12 - pw03) <<< 1;
   assign k02 = (pw13 + pw02) <<< 1;
   assign k10 = (pw12 + pw03) <<< 1;
   assign k11 = (K_HALF - pw11 - pw33) <<< 1;
   assign k12 = (pw23 - pw01) <<< 1;
   assign k20 = (pw13 - pw02) <<< 1;
   assign k21 = (pw23 + pw01) <<< 1;
   assign k22 = (K_HALF - pw11 - pw22) <<< 1;

   logic [1:0]               krow, kcol, msel;
   logic signed [MUL_AW-1:0] ksel;
   logic signed [Q_W-1:0]    qa, qb;
   logic signed [15:0]       m_pick;
   logic signed [D_W-1:0]    dval;
   logic [DIV_DW-1:0]        den;
   logic [NUM_W-1:0]         num_mag;
   logic signed [NUM_W-1:0]  quot_s;

   assign krow   = (state_ff == S_GB) ? 2'd2 : idx_ff[1:0];
   assign kcol   = (state_ff == S_GB) ? idx_ff[1:0] : col_ff;
   assign msel   = (state_ff == S_RT) ? col_ff : idx_ff[1:0];
   assign m_pick = m_ff[msel];
   assign dval   = D_W'(acc_ff[idx_ff[1:0]]) - D_W'(gb_ff[idx_ff[1:0]]);
   assign den    = {1'b0, tc_ff} + {1'b0, dt_ff};
   assign num_mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign quot_s  = num_ff[NUM_W-1] ? -$signed({2'b00, div_rsp.quot})
                                    : $signed({2'b00, div_rsp.quot});

   always_comb begin
      case ({krow, kcol})
         4'h0:    ksel = k00;
         4'h1:    ksel = k01;
         4'h2:    ksel = k02;
         4'h4:    ksel = k10;
         4'h5:    ksel = k11;
         4'h6:    ksel = k12;
         4'h8:    ksel = k20;
         4'h9:    ksel = k21;
         4'ha:    ksel = k22;
         default: ksel = '0;
      endcase
   end

   // quaternion pairs in product order: 01 02 03 12 13 23 11 22 33
   always_comb begin
      case (idx_ff)
         4'd0:    begin qa = q_ff[0]; qb = q_ff[1]; end
         4'd1:    begin qa = q_ff[0]; qb = q_ff[2]; end
         4'd2:    begin qa = q_ff[0]; qb = q_ff[3]; end
         4'd3:    begin qa = q_ff[1]; qb = q_ff[2]; end
         4'd4:    begin qa = q_ff[1]; qb = q_ff[3]; end
         4'd5:    begin qa = q_ff[2]; qb = q_ff[3]; end
         4'd6:    begin qa = q_ff[1]; qb = q_ff[1]; end
         4'd7:    begin qa = q_ff[2]; qb = q_ff[2]; end
         4'd8:    begin qa = q_ff[3]; qb = q_ff[3]; end
         default: begin qa = '0;      qb = '0;      end
      endcase
   end

   // update-step helpers
   logic signed [16:0]      e0w, e1w, e2w;
   logic [16:0]             e0a, e1a, e2a;
   logic signed [15:0]      ex, ey, ez;
   logic [7:0]              still_n;
   logic                    vclr;
   logic signed [VEL_W-1:0] vel_c;
   logic signed [VEL_W:0]   vsum;
   logic signed [16:0]      ydiff;
   logic signed [POS_W:0]   psum;
   logic signed [31:0]      yaw_total;
   logic                    run_now;

   assign e0w = 17'(e_ff[0]);
   assign e1w = 17'(e_ff[1]);
   assign e2w = 17'(e_ff[2]);
   assign e0a = e0w[16] ? 17'(-e0w) : 17'(e0w);
   assign e1a = e1w[16] ? 17'(-e1w) : 17'(e1w);
   assign e2a = e2w[16] ? 17'(-e2w) : 17'(e2w);
   assign ex  = (e0a < {7'b0, dbh_ff}) ? 16'sd0 : e_ff[0];
   assign ey  = (e1a < {7'b0, dbh_ff}) ? 16'sd0 : e_ff[1];
   assign ez  = (e2a < {7'b0, dbv_ff}) ? 16'sd0 : e_ff[2];
   assign still_n = ((e2a < {7'b0, dbv_ff}) && (still_ff != 8'hff)) ? still_ff + 8'd1
                                                                     : still_ff;
   assign vclr    = (still_n > lim_ff);
   assign vel_c   = vclr ? '0 : vel_ff;
   assign vsum    = (VEL_W+1)'(vel_c) + (VEL_W+1)'(ey);
   assign ydiff   = 17'(yaw_ff) - 17'(yprev_ff);
   assign run_now = (warm_ff > wsteps_ff);
   assign psum    = (POS_W+1)'(pos_ff) + (POS_W+1)'(vel_ff);
   assign yaw_total = 32'(turns_ff) * TURN_Q12 + 32'(yprev_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      col_in    = col_ff;
      go_in     = go_ff;
      tc_in     = tc_ff;
      dbh_in    = dbh_ff;
      dbv_in    = dbv_ff;
      lim_in    = lim_ff;
      wsteps_in = wsteps_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      yaw_in    = yaw_ff;
      dt_in     = dt_ff;
      p_in      = p_ff;
      gb_in     = gb_ff;
      num_in    = num_ff;
      racc_in   = racc_ff;
      e_in      = e_ff;
      run_in    = run_ff;
      m_in      = m_ff;
      vel_in    = vel_ff;
      pos_in    = pos_ff;
      still_in  = still_ff;
      warm_in   = warm_ff;
      turns_in  = turns_ff;
      yprev_in  = yprev_ff;
      rdy_in    = rdy_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mul_req.start = 1'b0;
      mul_req.a     = ksel;
      mul_req.b     = MUL_BW'(m_pick);
      div_req.start = 1'b0;
      div_req.num   = DIV_NW'(num_mag + NUM_W'(den >> 1));
      div_req.den   = den;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_LOWPASS_TIME: tc_in     = csr_data;
            CSR_DEADBAND_HOR: dbh_in    = csr_data[9:0];
            CSR_DEADBAND_VER: dbv_in    = csr_data[9:0];
            CSR_STILL_LIMIT:  lim_in    = csr_data[7:0];
            CSR_WARMUP_STEPS: wsteps_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               acc_in[0] = req_tdata[15:0];
               acc_in[1] = req_tdata[31:16];
               acc_in[2] = req_tdata[47:32];
               q_in[0]   = req_tdata[63:48];
               q_in[1]   = req_tdata[79:64];
               q_in[2]   = req_tdata[95:80];
               q_in[3]   = req_tdata[111:96];
               yaw_in    = req_tdata[126:112];
               dt_in     = req_tdata[142:127];
               idx_in    = '0;
               col_in    = '0;
               go_in     = 1'b0;
               state_in  = S_QP;
            end
         end
         S_QP: begin
            mul_req.a = MUL_AW'(qa);
            mul_req.b = MUL_BW'(qb);
            if (!go_ff) begin
               mul_req.start = 1'b1;
               go_in = 1'b1;
            end else if (mul_rsp.done) begin
               p_in[idx_ff] = 32'(mul_rsp.prod);
               go_in = 1'b0;
               if (idx_ff == 4'(PROD_CNT - 1)) begin
                  idx_in   = '0;
                  state_in = S_GB;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_GB: begin
            mul_req.b = GRAVITY_Q10;
            if (!go_ff) begin
               mul_req.start = 1'b1;
               go_in = 1'b1;
            end else if (mul_rsp.done) begin
               gb_in[idx_ff[1:0]] = GB_W'(rsr28(mul_rsp.prod));
               go_in = 1'b0;
               if (idx_ff == 4'd2) begin
                  idx_in   = '0;
                  // zero time constant and zero step hold the filter
                  state_in = (den != '0) ? S_FD : S_RT;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         S_FD: begin
            mul_req.a = MUL_AW'(dval);
            mul_req.b = MUL_BW'($signed({1'b0, dt_ff}));
            if (!go_ff) begin
               mul_req.start = 1'b1;
               go_in = 1'b1;
            end else if (mul_rsp.done) begin
               num_in   = NUM_W'(mul_rsp.prod);
               go_in    = 1'b0;
               state_in = S_FM;
            end
         end
         S_FM: begin
            mul_req.a = MUL_AW'(m_pick);
            mul_req.b = MUL_BW'($signed({1'b0, tc_ff}));
            if (!go_ff) begin
               mul_req.start = 1'b1;
               go_in = 1'b1;
            end else if (mul_rsp.done) begin
               num_in   = num_ff + NUM_W'(mul_rsp.prod);
               go_in    = 1'b0;
               state_in = S_DV;
            end
         end
         S_DV: begin
            if (!go_ff) begin
               div_req.start = 1'b1;
               go_in = 1'b1;
            end else if (div_rsp.done) begin
               m_in[idx_ff[1:0]] = sat16(PROD_W'(quot_s));
               go_in = 1'b0;
               if (idx_ff == 4'd2) begin
                  idx_in   = '0;
                  col_in   = '0;
                  state_in = S_RT;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_FD;
               end
            end
         end
         S_RT: begin
            if (!go_ff) begin
               mul_req.start = 1'b1;
               go_in = 1'b1;
            end else if (mul_rsp.done) begin
               racc_in = ((col_ff == 2'd0) ? prod_type'(0) : racc_ff) + mul_rsp.prod;
               go_in   = 1'b0;
               if (col_ff == 2'd2) begin
                  state_in = S_RND;
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         S_RND: begin
            e_in[idx_ff[1:0]] = sat16(rsr28(racc_ff));
            col_in = '0;
            if (idx_ff == 4'd2) begin
               state_in = S_UPD;
            end else begin
               idx_in   = idx_ff + 4'd1;
               state_in = S_RT;
            end
         end
         S_UPD: begin
            e_in[0]  = ex;
            e_in[1]  = ey;
            e_in[2]  = ez;
            still_in = vclr ? 8'd0 : still_n;
            run_in   = run_now;
            if (run_now) begin
               if (vsum > (VEL_W+1)'(33'sh0_7fff_ffff)) begin
                  vel_in = 32'sh7fff_ffff;
               end else if (vsum < -(VEL_W+1)'(33'sh0_8000_0000)) begin
                  vel_in = 32'sh8000_0000;
               end else begin
                  vel_in = VEL_W'(vsum);
               end
               rdy_in = 1'b1;
               if (ydiff >= PI_Q12) begin
                  if (turns_ff != 16'sh8000) turns_in = turns_ff - 16'sd1;
               end else if (ydiff <= -PI_Q12) begin
                  if (turns_ff != 16'sh7fff) turns_in = turns_ff + 16'sd1;
               end
               yprev_in = 16'(yaw_ff);
            end else begin
               vel_in = vel_c;
               if (warm_ff != 16'hffff) warm_in = warm_ff + 16'd1;
            end
            state_in = S_POS;
         end
         S_POS: begin
            if (run_ff) begin
               if (psum[POS_W] != psum[POS_W-1]) begin
                  pos_in = psum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                       : {1'b0, {(POS_W-1){1'b1}}};
               end else begin
                  pos_in = POS_W'(psum);
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {yaw_total, pos_ff, vel_ff, e_ff[2], e_ff[1], e_ff[0]};
               rsp_user_in  = rdy_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         col_ff       <= '0;
         go_ff        <= 1'b0;
         tc_ff        <= 16'd8900;
         dbh_ff       <= 10'd20;
         dbv_ff       <= 10'd41;
         lim_ff       <= 8'd10;
         wsteps_ff    <= 16'd3000;
         m_ff         <= '{default: '0};
         vel_ff       <= '0;
         pos_ff       <= '0;
         still_ff     <= '0;
         warm_ff      <= '0;
         turns_ff     <= '0;
         yprev_ff     <= '0;
         rdy_ff       <= 1'b0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         go_ff        <= go_in;
         tc_ff        <= tc_in;
         dbh_ff       <= dbh_in;
         dbv_ff       <= dbv_in;
         lim_ff       <= lim_in;
         wsteps_ff    <= wsteps_in;
         m_ff         <= m_in;
         vel_ff       <= vel_in;
         pos_ff       <= pos_in;
         still_ff     <= still_in;
         warm_ff      <= warm_in;
         turns_ff     <= turns_in;
         yprev_ff     <= yprev_in;
         rdy_ff       <= rdy_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      yaw_ff      <= yaw_in;
      dt_ff       <= dt_in;
      p_ff        <= p_in;
      gb_ff       <= gb_in;
      num_ff      <= num_in;
      racc_ff     <= racc_in;
      e_ff        <= e_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

   // a product is only launched on an idle multiplier
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_rsp.busy)
      else $error("multiplier started while busy");

   // the divider never sees a zero denominator
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.den != '0))
      else $error("divide by zero launched");

   // once integration has run the ready flag stays set
   a_rdy_sticky: assert property (@(posedge clock) disable iff (reset)
      rdy_ff |=> rdy_ff)
      else $error("ready flag dropped");

   // an accepted word always starts the quaternion products
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_QP && idx_ff == '0))
      else $error("accepted word did not start the sequence");

endmodule

`default_nettype wire

// File: dv/imu_motion_accel_integrator_checker.sv
// checker for the imu motion integrator: watches the sample, result and register channels,
// predicts each result word from its own model of the datapath and compares field by field
// depends on imac_pkg for widths and register indexes
`timescale 1ns / 1ps

module imu_motion_accel_integrator_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [imac_pkg::IN_DATA_W-1:0]   req_tdata,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [imac_pkg::OUT_DATA_W-1:0]  rsp_tdata,
   input  wire logic                             rsp_tuser,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [imac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [imac_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                    mismatch_count,
   output int                                    pending_count
);
   import imac_pkg::*;

   localparam longint GRAV   = 10045;
   localparam longint HALF28 = 64'sd134217728;
   localparam longint PI_Q   = 12868;
   localparam longint TURN_Q = 25735;
   localparam longint POS_HI = (64'sd1 <<< 47) - 1;
   localparam longint POS_LO = -(64'sd1 <<< 47);

   typedef struct {
      logic signed [15:0] earth_x;
      logic signed [15:0] earth_y;
      logic signed [15:0] earth_z;
      logic signed [31:0] vel;
      logic signed [47:0] pos;
      logic signed [31:0] yaw_sum;
      logic               running;
   } motion_word_type;

   motion_word_type motion_q[$];

   // register copies
   longint tau_us, band_xy, band_z, still_max, warm_len;
   // datapath state
   longint filt[3];
   longint vel_acc, pos_acc, still_cnt, warm_cnt, turns, yaw_prev;
   logic   running_flag;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round_shift28(input longint v);
      if (v >= 0) return (v + HALF28) >>> 28;
      return -((-v + HALF28) >>> 28);
   endfunction

   function automatic longint round_div(input longint num, input longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   task automatic predict_motion(input logic [IN_DATA_W-1:0] w, output motion_word_type r);
      longint a[3], gb[3], e[3];
      longint q0, q1, q2, q3, yaw, dt, mm, diff, total, m0, m1, m2;
      int i;
      a[0] = longint'($signed(w[15:0]));
      a[1] = longint'($signed(w[31:16]));
      a[2] = longint'($signed(w[47:32]));
      q0   = longint'($signed(w[63:48]));
      q1   = longint'($signed(w[79:64]));
      q2   = longint'($signed(w[95:80]));
      q3   = longint'($signed(w[111:96]));
      yaw  = longint'($signed(w[126:112]));
      dt   = longint'(w[142:127]);

      // gravity seen in the body frame
      gb[0] = round_shift28(2 * (q1 * q3 - q0 * q2) * GRAV);
      gb[1] = round_shift28(2 * (q2 * q3 + q0 * q1) * GRAV);
      gb[2] = round_shift28(2 * (HALF28 - q1 * q1 - q2 * q2) * GRAV);

      // low-pass held when both times are zero
      if (tau_us + dt != 0) begin
         for (i = 0; i < 3; i++) begin
            mm = round_div((a[i] - gb[i]) * dt + filt[i] * tau_us, tau_us + dt);
            filt[i] = clamp(mm, -32768, 32767);
         end
      end

      m0 = filt[0];
      m1 = filt[1];
      m2 = filt[2];
      e[0] = 2 * ((HALF28 - q2 * q2 - q3 * q3) * m0 + (q1 * q2 - q0 * q3) * m1
                  + (q1 * q3 + q0 * q2) * m2);
      e[1] = 2 * ((q1 * q2 + q0 * q3) * m0 + (HALF28 - q1 * q1 - q3 * q3) * m1
                  + (q2 * q3 - q0 * q1) * m2);
      e[2] = 2 * ((q1 * q3 - q0 * q2) * m0 + (q2 * q3 + q0 * q1) * m1
                  + (HALF28 - q1 * q1 - q2 * q2) * m2);
      for (i = 0; i < 3; i++) e[i] = clamp(round_shift28(e[i]), -32768, 32767);

      if ((e[0] < 0 ? -e[0] : e[0]) < band_xy) e[0] = 0;
      if ((e[1] < 0 ? -e[1] : e[1]) < band_xy) e[1] = 0;
      if ((e[2] < 0 ? -e[2] : e[2]) < band_z) begin
         e[2] = 0;
         if (still_cnt < 255) still_cnt++;
      end
      if (still_cnt > still_max) begin
         still_cnt = 0;
         vel_acc = 0;
      end

      if (warm_cnt > warm_len) begin
         vel_acc = clamp(vel_acc + e[1], -64'sd2147483648, 64'sd2147483647);
         pos_acc = clamp(pos_acc + vel_acc, POS_LO, POS_HI);
         running_flag = 1'b1;
         diff = yaw - yaw_prev;
         if (diff >= PI_Q) begin
            if (turns > -32768) turns--;
         end else if (diff <= -PI_Q) begin
            if (turns < 32767) turns++;
         end
         yaw_prev = yaw;
      end else if (warm_cnt < 65535) begin
         warm_cnt++;
      end
      total = TURN_Q * turns + yaw_prev;

      r.earth_x = 16'(e[0]);
      r.earth_y = 16'(e[1]);
      r.earth_z = 16'(e[2]);
      r.vel     = 32'(vel_acc);
      r.pos     = 48'(pos_acc);
      r.yaw_sum = 32'(total);
      r.running = running_flag;
   endtask

   task automatic compare_word(input motion_word_type x, input motion_word_type y);
      if (x.earth_x !== y.earth_x || x.earth_y !== y.earth_y || x.earth_z !== y.earth_z) begin
         $display("%t earth accel mismatch: expected %0d %0d %0d, actual %0d %0d %0d", $time,
                  x.earth_x, x.earth_y, x.earth_z, y.earth_x, y.earth_y, y.earth_z);
         mismatch_count++;
      end
      if (x.vel !== y.vel) begin
         $display("%t velocity mismatch: expected %0d, actual %0d", $time, x.vel, y.vel);
         mismatch_count++;
      end
      if (x.pos !== y.pos) begin
         $display("%t position mismatch: expected %0d, actual %0d", $time, x.pos, y.pos);
         mismatch_count++;
      end
      if (x.yaw_sum !== y.yaw_sum) begin
         $display("%t yaw total mismatch: expected %0d, actual %0d", $time, x.yaw_sum,
                  y.yaw_sum);
         mismatch_count++;
      end
      if (x.running !== y.running) begin
         $display("%t ready flag mismatch: expected %0b, actual %0b", $time, x.running,
                  y.running);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      motion_word_type predicted, seen;
      if (reset) begin
         tau_us = 8900; band_xy = 20; band_z = 41; still_max = 10; warm_len = 3000;
         filt[0] = 0; filt[1] = 0; filt[2] = 0;
         vel_acc = 0; pos_acc = 0; still_cnt = 0; warm_cnt = 0;
         turns = 0; yaw_prev = 0; running_flag = 1'b0;
         motion_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LOWPASS_TIME: tau_us    = longint'(csr_data);
               CSR_DEADBAND_HOR: band_xy   = longint'(csr_data[9:0]);
               CSR_DEADBAND_VER: band_z    = longint'(csr_data[9:0]);
               CSR_STILL_LIMIT:  still_max = longint'(csr_data[7:0]);
               CSR_WARMUP_STEPS: warm_len  = longint'(csr_data);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_motion(req_tdata, predicted);
            motion_q.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.earth_x = rsp_tdata[15:0];
            seen.earth_y = rsp_tdata[31:16];
            seen.earth_z = rsp_tdata[47:32];
            seen.vel     = rsp_tdata[79:48];
            seen.pos     = rsp_tdata[127:80];
            seen.yaw_sum = rsp_tdata[159:128];
            seen.running = rsp_tuser;
            if (motion_q.size() == 0) begin
               $display("%t result word with none expected: expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               compare_word(motion_q.pop_front(), seen);
            end
         end
      end
      pending_count = motion_q.size();
   end

endmodule

// File: dv/imu_motion_accel_integrator_top_test.sv
// testbench top for imu_motion_accel_integrator_top: clock, reset, sample and register stimulus,
// random stalls on both channels and the verdict; depends on imac_pkg and the checker module
`timescale 1ns / 1ps

module imu_motion_accel_integrator_top_test;
   import imac_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z, yaw_angle, step_time_us
   logic [IN_DATA_W-1:0]  req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // earth_accel_x, earth_accel_y, earth_accel_z, velocity, position, yaw_total
   logic [OUT_DATA_W-1:0] rsp_tdata;
   // ready_res
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int mismatch_count;
   int pending_count;

   // idling on for a phase or a stretch of steady traffic
   bit idle_on;
   // running yaw for well-formed sequences, wraps past pi now and then
   int yaw_walk;

   imu_motion_accel_integrator_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   imu_motion_accel_integrator_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit: even with the longest gaps and stalls a correct run ends well before this
   initial begin
      #80000000;
      $display("simulation failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 400);
   endfunction

   function automatic logic [IN_DATA_W-1:0] pack_sample(
      input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
      input logic [15:0] qw, input logic [15:0] qx, input logic [15:0] qy,
      input logic [15:0] qz, input logic [14:0] yaw, input logic [15:0] dt);
      return {1'b0, dt, yaw, qz, qy, qx, qw, az, ay, ax};
   endfunction

   function automatic logic [15:0] rand_quat();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // accept-side driver: valid stays high across back-to-back words
   task automatic send_word(input logic [IN_DATA_W-1:0] w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_motion(input int ax, input int ay, input int az, input int qw,
                              input int qx, input int qy, input int qz, input int yaw,
                              input int dt);
      send_word(pack_sample(16'(ax), 16'(ay), 16'(az), 16'(qw), 16'(qx), 16'(qy), 16'(qz),
                            15'(yaw), 16'(dt)));
   endtask

   // well-formed motion most of the time, raw noise otherwise
   task automatic send_random();
      int qw;
      if ($urandom_range(0, 99) < 75) begin
         yaw_walk += $signed($urandom_range(0, 1600)) - 800;
         if (yaw_walk > 12868) yaw_walk -= 25735;
         if (yaw_walk < -12868) yaw_walk += 25735;
         if ($urandom_range(0, 19) == 0) yaw_walk = $signed($urandom_range(0, 25736)) - 12868;
         qw = $urandom_range(9000, 16384);
         if ($urandom_range(0, 1)) qw = -qw;
         send_motion($signed($urandom_range(0, 8000)) - 4000,
                     $signed($urandom_range(0, 8000)) - 4000,
                     10045 + $signed($urandom_range(0, 6000)) - 3000,
                     qw,
                     $signed($urandom_range(0, 12000)) - 6000,
                     $signed($urandom_range(0, 12000)) - 6000,
                     $signed($urandom_range(0, 12000)) - 6000,
                     yaw_walk, $urandom_range(500, 2000));
      end else begin
         send_word(pack_sample(16'($urandom), 16'($urandom), 16'($urandom), rand_quat(),
                               rand_quat(), rand_quat(), rand_quat(),
                               15'($urandom), 16'($urandom_range(1, 65535))));
      end
   endtask

   // registers only change with the datapath drained; the caller drops valid after the last write
   task automatic write_reg(input csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input int tau, input int bxy, input int bz, input int still,
                            input int warm);
      req_tvalid <= 1'b0;
      // let the checker count the word accepted at this edge
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
      write_reg(CSR_LOWPASS_TIME, tau);
      write_reg(CSR_DEADBAND_HOR, bxy);
      write_reg(CSR_DEADBAND_VER, bz);
      write_reg(CSR_STILL_LIMIT, still);
      write_reg(CSR_WARMUP_STEPS, warm);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         // toggle between steady traffic and idling stretches
         if (i % 50 == 0) idle_on = $urandom_range(0, 3) != 0;
         send_random();
      end
   endtask

   // result side: random stalls of varied length
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_LOWPASS_TIME;
      csr_data   = '0;
      idle_on    = 1'b1;
      yaw_walk   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the register defaults: field extremes, unnormalized quaternions
      send_motion(0, 0, 10045, 16384, 0, 0, 0, 0, 1000);
      send_motion(32767, 32767, 32767, 16384, 16384, 16384, 16384, 12868, 65535);
      send_motion(-32768, -32768, -32768, -16384, -16384, -16384, -16384, -12868, 65535);
      send_motion(32767, -32768, 32767, 16384, -16384, 16384, -16384, 16383, 1);
      send_motion(-32768, 32767, -32768, -16384, 16384, -16384, 16384, -16384, 1);
      send_motion(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_motion(5, -5, 30, 16384, 0, 0, 0, 100, 1000);
      send_motion(0, 0, 0, 0, 16384, 0, 0, 0, 32768);
      send_motion(100, 200, 10045, 11585, 0, 0, 11585, 0, 1000);
      send_motion(-1, -1, -1, -1, -1, -1, -1, -1, 65535);

      // everything at its low end: zero time constant, warm-up over at once
      configure(0, 0, 0, 0, 0);
      send_motion(1000, 2000, 3000, 16384, 0, 0, 0, 0, 1000);
      send_motion(-9000, 9000, 500, 16384, 0, 0, 0, 0, 0);
      send_motion(0, 4000, 10045, 16384, 0, 0, 0, 12000, 500);
      send_motion(0, 4000, 10045, 16384, 0, 0, 0, -12000, 500);
      send_motion(0, 4000, 10045, 16384, 0, 0, 0, 12000, 500);
      send_motion(0, -32768, 10045, 16384, 0, 0, 0, -868, 500);
      send_motion(0, 32767, 10045, 16384, 0, 0, 0, 12868, 500);
      send_motion(0, 0, 10045, 16384, 0, 0, 0, -16384, 500);
      send_motion(0, 0, 10045, 16384, 0, 0, 0, 16383, 500);
      send_motion(32767, 32767, -32768, 16384, 16384, 16384, 16384, 0, 65535);
      random_phase(150);

      // upper extremes for the time constant, deadbands and still limit
      configure(65535, 1023, 1023, 255, 5);
      random_phase(200);

      configure($urandom_range(0, 65535), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 255), $urandom_range(0, 40));
      random_phase(200);

      // warm-up raised after integration started: ready stays set
      configure($urandom_range(0, 20000), 20, 41, 10, 65535);
      random_phase(150);

      configure($urandom_range(0, 65535), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 255), $urandom_range(0, 65535));
      random_phase(150);

      configure(8900, 20, 41, 10, 0);
      random_phase(150);

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
